[design/uf_pkg.sv]
package uf_pkg;

  // Table geometry and field widths
  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int SIZE_W       = 11;
  localparam int ENT_W        = SIZE_W + 1;
  localparam int OP_W         = 2;

  // Stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - 1 - SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_FIND  = 2'd0,
    OP_SAME  = 2'd1,
    OP_SIZE  = 2'd2,
    OP_UNITE = 2'd3
  } uf_op_t;

  // Result selection for the output register
  typedef enum logic [1:0] {
    RES_FIND  = 2'd0,
    RES_SAME  = 2'd1,
    RES_UNITE = 2'd2,
    RES_ERR   = 2'd3
  } uf_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    clr;       // write reset entry at clear counter
    logic    accept;    // latch request, start walk at elem_a
    logic    begin_b;   // start walk at elem_b
    logic    rd_cur;    // read table at walk pointer
    logic    walk;      // follow link or capture root
    logic    comp;      // rewrite walked entry to point at root
    logic    store_a;   // keep root/size of elem_a
    logic    store_b;   // keep root/size of elem_b
    logic    pick;      // choose winner root and merged size
    logic    wr_win;    // write winner root entry
    logic    wr_lose;   // link loser root under winner
    logic    out_load;  // load output register
    uf_res_t res_sel;
  } uf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    uf_op_t op;
    logic   rd_root;     // entry just read is a root
    logic   cur_at_root; // compression pointer reached the root
    logic   roots_eq;    // both operands share a root
    logic   clr_last;    // clear counter at last entry
    logic   in_err;      // incoming request names an index past the table
    logic   out_free;    // output register can take a result
  } uf_sts_t;

endpackage

[design/uf_dp.sv]
module uf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  uf_pkg::uf_cmd_t                cmd,
  output uf_pkg::uf_sts_t                sts,
  input  logic [uf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [uf_pkg::OP_W-1:0]        in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [uf_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import uf_pkg::*;

  // Link table: [ENT_W-1] root bit, low bits size (root) or parent index
  logic [ENT_W-1:0]  mem [NUM_ELEMENTS];
  logic [ENT_W-1:0]  rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;

  logic [IDX_W-1:0]  clr_cnt_r;
  uf_op_t            op_r;
  logic [IDX_W-1:0]  a_r, b_r;
  logic [IDX_W-1:0]  cur_r, start_r;
  logic [IDX_W-1:0]  root_r;
  logic [SIZE_W-1:0] rootsz_r;
  logic [IDX_W-1:0]  ra_r, rb_r;
  logic [SIZE_W-1:0] sa_r, sb_r;
  logic [IDX_W-1:0]  win_r, lose_r;
  logic [SIZE_W-1:0] sum_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [IDX_W-1:0]  out_root_r;
  logic              out_flag_r;
  logic [SIZE_W-1:0] out_size_r;

  logic [IDX_W-1:0]  in_a, in_b;
  uf_op_t            in_op;
  logic              in_uses_b;
  logic              rd_root;
  logic [SIZE_W-1:0] rd_val;
  logic [IDX_W-1:0]  rd_link;
  logic [SIZE_W:0]   sum_full;

  // Request fields
  assign in_a      = in_tdata[IDX_W-1:0];
  assign in_b      = in_tdata[2*IDX_W-1:IDX_W];
  assign in_op     = uf_op_t'(in_tuser);
  assign in_uses_b = (in_op == OP_SAME) || (in_op == OP_UNITE);

  // Read data fields
  assign rd_root = rd_data_r[ENT_W-1];
  assign rd_val  = rd_data_r[SIZE_W-1:0];
  assign rd_link = rd_val[IDX_W-1:0];

  // Table port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_r;
    if (cmd.rd_cur) begin
      rd_en = 1'b1;
    end else if (cmd.walk && !rd_root) begin
      rd_en   = 1'b1;
      rd_addr = rd_link;
    end
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = {1'b0, SIZE_W'(root_r)};
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = {1'b1, SIZE_W'(1)};
    end else if (cmd.comp) begin
      wr_en = 1'b1;
    end else if (cmd.wr_win) begin
      wr_en   = 1'b1;
      wr_addr = win_r;
      wr_data = {1'b1, sum_r};
    end else if (cmd.wr_lose) begin
      wr_en   = 1'b1;
      wr_addr = lose_r;
      wr_data = {1'b0, SIZE_W'(win_r)};
    end
  end

  // Link table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end

  // Merged size, saturated
  assign sum_full = {1'b0, sa_r} + {1'b0, sb_r};

  // Walk, compression and merge registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      a_r     <= in_a;
      b_r     <= in_b;
      cur_r   <= in_a;
      start_r <= in_a;
    end
    if (cmd.begin_b) begin
      cur_r   <= b_r;
      start_r <= b_r;
    end
    if (cmd.walk) begin
      if (rd_root) begin
        root_r   <= cur_r;
        rootsz_r <= rd_val;
        cur_r    <= start_r;
      end else begin
        cur_r <= rd_link;
      end
    end
    if (cmd.comp) begin
      cur_r <= rd_link;
    end
    if (cmd.store_a) begin
      ra_r <= root_r;
      sa_r <= rootsz_r;
    end
    if (cmd.store_b) begin
      rb_r <= root_r;
      sb_r <= rootsz_r;
    end
    if (cmd.pick) begin
      // larger set wins, elem_a's root on a tie
      if (sa_r < sb_r) begin
        win_r  <= rb_r;
        lose_r <= ra_r;
      end else begin
        win_r  <= ra_r;
        lose_r <= rb_r;
      end
      sum_r <= sum_full[SIZE_W] ? SIZE_MAX : sum_full[SIZE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RES_FIND: begin
          out_root_r <= ra_r;
          out_flag_r <= 1'b0;
          out_size_r <= sa_r;
        end
        RES_SAME: begin
          out_root_r <= ra_r;
          out_flag_r <= (ra_r == rb_r);
          out_size_r <= sa_r;
        end
        RES_UNITE: begin
          out_root_r <= win_r;
          out_flag_r <= 1'b1;
          out_size_r <= sum_r;
        end
        default: begin
          out_root_r <= a_r;
          out_flag_r <= 1'b0;
          out_size_r <= '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_size_r, out_flag_r, out_root_r};

  // Status
  assign sts.op          = op_r;
  assign sts.rd_root     = rd_root;
  assign sts.cur_at_root = (cur_r == root_r);
  assign sts.roots_eq    = (ra_r == rb_r);
  assign sts.clr_last    = (clr_cnt_r == IDX_W'(NUM_ELEMENTS - 1));
  assign sts.in_err      = ({1'b0, in_a} >= (IDX_W + 1)'(NUM_ELEMENTS)) ||
                           (in_uses_b && ({1'b0, in_b} >= (IDX_W + 1)'(NUM_ELEMENTS)));
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule

[design/uf_ctrl.sv]
module uf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output uf_pkg::uf_cmd_t cmd,
  input  uf_pkg::uf_sts_t sts
);
  import uf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FRD,
    S_FWT,
    S_CCHK,
    S_CWT,
    S_EVAL,
    S_UW1,
    S_UW2,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  logic    phase_r, phase_nxt;    // 0: walking elem_a, 1: walking elem_b
  uf_res_t res_sel_r, res_sel_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    res_sel_nxt = res_sel_r;
    cmd         = '0;
    cmd.res_sel = res_sel_r;
    in_tready   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          phase_nxt  = 1'b0;
          if (sts.in_err) begin
            res_sel_nxt = RES_ERR;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_FWT;
      end
      S_FWT: begin
        cmd.walk = 1'b1;
        if (sts.rd_root) begin
          state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        if (sts.cur_at_root) begin
          if (!phase_r) begin
            cmd.store_a = 1'b1;
            if (sts.op == OP_FIND || sts.op == OP_SIZE) begin
              res_sel_nxt = RES_FIND;
              state_nxt   = S_DONE;
            end else begin
              cmd.begin_b = 1'b1;
              phase_nxt   = 1'b1;
              state_nxt   = S_FRD;
            end
          end else begin
            cmd.store_b = 1'b1;
            state_nxt   = S_EVAL;
          end
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_CWT;
        end
      end
      S_CWT: begin
        cmd.comp  = 1'b1;
        state_nxt = S_CCHK;
      end
      S_EVAL: begin
        if (sts.op == OP_SAME) begin
          res_sel_nxt = RES_SAME;
          state_nxt   = S_DONE;
        end else if (sts.roots_eq) begin
          res_sel_nxt = RES_FIND;
          state_nxt   = S_DONE;
        end else begin
          cmd.pick  = 1'b1;
          state_nxt = S_UW1;
        end
      end
      S_UW1: begin
        cmd.wr_win = 1'b1;
        state_nxt  = S_UW2;
      end
      S_UW2: begin
        cmd.wr_lose = 1'b1;
        res_sel_nxt = RES_UNITE;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      phase_r   <= 1'b0;
      res_sel_r <= RES_FIND;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      res_sel_r <= res_sel_nxt;
    end
  end

endmodule

[design/union_find_engine.sv]
// Channel | Direction | Transaction
// in_*    | slave     | tuser: req_type [1:0]; tdata: elem_a [9:0], elem_b [19:10]
// out_*   | master    | tdata: root_index [9:0], flag [10], set_size [21:11]
//
// One request at a time. A find over a path of depth d walks the link table
// to the root, then takes one read and one write per compressed node; depth
// stays at most 10.
// After reset a clearing pass writes every entry; no request is taken
// meanwhile. A finished result waits in the output register while the
// next request is accepted and worked on.
module union_find_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [uf_pkg::IN_DATA_W-1:0]   in_tdata,  // elem_a, elem_b
  input  logic [uf_pkg::OP_W-1:0]        in_tuser,  // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [uf_pkg::OUT_DATA_W-1:0]  out_tdata  // root_index, flag, set_size
);
  import uf_pkg::*;

  uf_cmd_t cmd;
  uf_sts_t sts;

  // Sequencer
  uf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Link table and result registers
  uf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A set never grows past the table
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[21:11] <= 11'(NUM_ELEMENTS)))
    else $error("set size beyond element count");

  // An empty size only comes with a rejected request, which never sets flag
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[21:11] == 11'd0) |-> !out_tdata[10])
    else $error("flag set on rejected request");

  // One request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while one is in flight");

  // A result is loaded only after a request was accepted
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !in_tready)
    else $error("result loaded while idle");

endmodule
